/* hdl/spft_pkg.sv */
// Shared types and constants for the sequenced pulse firing timer.
package spft_pkg;

	// Default number of channels in the firing row.
	localparam int SPFT_CHANNELS = 32;

	// Reset contents of the delay table and the pulse length register.
	localparam logic [15:0] DEFAULT_DELAY = 16'd200;
	localparam logic [15:0] DEFAULT_PULSE = 16'd50;

	// Field widths.
	localparam int OPCODE_W = 2;
	localparam int ENTRY_W  = 5;
	localparam int DELAY_W  = 16;
	localparam int TIME_W   = 32;
	localparam int LEVELS_W = 32;
	localparam int CHAN_W   = 6;

	// Command codes.
	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK  = 2'd0,
		OP_PRESS = 2'd1,
		OP_LOAD  = 2'd2
	} opcode_t;

endpackage

/* hdl/spft_cmd_if.sv */
// Command channel: tick, press and delay load items.
interface spft_cmd_if
	import spft_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [ENTRY_W-1:0]  entry_index;
	logic [DELAY_W-1:0]  entry_delay;

	modport source (output valid, output opcode, output entry_index, output entry_delay,
		input ready);
	modport sink (input valid, input opcode, input entry_index, input entry_delay,
		output ready);
endinterface

/* hdl/spft_rsp_if.sv */
// Result channel: channel levels and sequencer status after each item.
interface spft_rsp_if
	import spft_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [LEVELS_W-1:0] channel_levels;
	logic [CHAN_W-1:0]   channel_index;
	logic                running;
	logic                fired;

	modport source (output valid, output channel_levels, output channel_index,
		output running, output fired, input ready);
	modport sink (input valid, input channel_levels, input channel_index,
		input running, input fired, output ready);
endinterface

/* hdl/sequenced_pulse_firing_timer_top.sv */
// Sequenced pulse firing timer: every command transfer yields one result transfer. The block
// takes one command per clock cycle while the result side is not holding it back, and passes
// each command through the input register and then the result register; the single update
// stage between them is a 32-bit increment and compare plus one delay table read. Ticks
// advance a 32-bit counter while running; the current channel rises when the counter meets
// its scheduled rise time (fired is 1 in that result) and falls pulse_q ticks later, after
// which the next channel is scheduled at now plus its stored delay. After the last channel
// the sequencer stops, its counter, channel and fall time clear and its rise time reloads
// from the delay of channel 0. A press toggles between start and stop-and-reset; stop leaves
// the channel levels as they are. Delay loads with an index at or beyond CHANNELS are
// ignored. The pulse length register may be written only while no command is in flight.
// The delay table holds 200 in every entry after reset, so no clearing pass is needed.
module sequenced_pulse_firing_timer_top
	import spft_pkg::*;
#(
	parameter int CHANNELS = SPFT_CHANNELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [DELAY_W-1:0] cfg_wr_data,
	spft_cmd_if.sink           cmd,
	spft_rsp_if.source         rsp
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(CHANNELS);

	// Input register
	logic                s1_valid_q;
	logic [OPCODE_W-1:0] s1_opcode_s1;
	logic [ENTRY_W-1:0]  s1_index_s1;
	logic [DELAY_W-1:0]  s1_delay_s1;

	// Sequencer state
	logic [DELAY_W-1:0]  pulse_q;
	logic [TIME_W-1:0]   tick_q, rise_q, fall_q;
	logic [CHAN_W-1:0]   chan_q;
	logic                run_q, armed_q;
	logic [LEVELS_W-1:0] levels_q;
	logic [DELAY_W-1:0]  delay_q [CHANNELS];

	// Result register
	logic                rsp_valid_q;
	logic [LEVELS_W-1:0] rsp_levels_q;
	logic [CHAN_W-1:0]   rsp_chan_q;
	logic                rsp_run_q, rsp_fired_q;

	// Next state
	logic [TIME_W-1:0]   tick_n, rise_n, fall_n;
	logic [CHAN_W-1:0]   chan_n;
	logic                run_n, armed_n, fired_n;
	logic [LEVELS_W-1:0] levels_n;

	logic                advance;
	logic                cmd_xfer;
	logic [TIME_W-1:0]   tick_inc;
	logic [CHAN_W-1:0]   next_chan;
	logic                is_tick, rise_hit, fall_hit, more_chan;
	logic [IDX_W-1:0]    rd_idx;
	logic [DELAY_W-1:0]  rd_delay;
	logic [LEVELS_W-1:0] chan_bit;
	logic                load_wr;

	// Handshake: the stage moves when the result register is free or being drained
	assign advance   = s1_valid_q && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !s1_valid_q || advance;
	assign cmd_xfer  = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd_xfer) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			s1_opcode_s1 <= cmd.opcode;
			s1_index_s1  <= cmd.entry_index;
			s1_delay_s1  <= cmd.entry_delay;
		end
	end

	// Pulse length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= DEFAULT_PULSE;
		end else if (cfg_wr_en) begin
			pulse_q <= cfg_wr_data;
		end
	end

	// Compare terms and delay table read address
	assign tick_inc  = tick_q + TIME_W'(1);
	assign next_chan = chan_q + CHAN_W'(1);
	assign is_tick   = (s1_opcode_s1 == OP_TICK) && run_q;
	assign rise_hit  = (tick_inc == rise_q);
	assign fall_hit  = !rise_hit && (tick_inc == fall_q);
	assign more_chan = (next_chan < LAST_CHAN);
	assign rd_idx    = (is_tick && fall_hit && more_chan) ? next_chan[IDX_W-1:0] : '0;
	assign rd_delay  = delay_q[rd_idx];
	assign chan_bit  = LEVELS_W'(1) << chan_q[ENTRY_W-1:0];
	assign load_wr   = advance && (s1_opcode_s1 == OP_LOAD) &&
		(CHAN_W'(s1_index_s1) < LAST_CHAN);

	// Update for one item
	always_comb begin
		tick_n   = tick_q;
		rise_n   = rise_q;
		fall_n   = fall_q;
		chan_n   = chan_q;
		run_n    = run_q;
		armed_n  = armed_q;
		levels_n = levels_q;
		fired_n  = 1'b0;
		case (s1_opcode_s1)
			OP_TICK: begin
				if (run_q) begin
					tick_n = tick_inc;
					if (rise_hit) begin
						fall_n   = rise_q + TIME_W'(pulse_q);
						levels_n = levels_q | chan_bit;
						fired_n  = 1'b1;
					end else if (fall_hit) begin
						levels_n = levels_q & ~chan_bit;
						if (more_chan) begin
							chan_n = next_chan;
							rise_n = tick_inc + TIME_W'(rd_delay);
						end else begin
							// end of row: stop, armed_q stays clear
							run_n  = 1'b0;
							tick_n = '0;
							chan_n = '0;
							fall_n = '0;
							rise_n = TIME_W'(rd_delay);
						end
					end
				end
			end
			OP_PRESS: begin
				if (armed_q) begin
					armed_n = 1'b0;
					run_n   = 1'b1;
				end else begin
					armed_n = 1'b1;
					run_n   = 1'b0;
					tick_n  = '0;
					chan_n  = '0;
					fall_n  = '0;
					rise_n  = TIME_W'(rd_delay);
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			rise_q   <= TIME_W'(DEFAULT_DELAY);
			fall_q   <= '0;
			chan_q   <= '0;
			run_q    <= 1'b0;
			armed_q  <= 1'b1;
			levels_q <= '0;
		end else if (advance) begin
			tick_q   <= tick_n;
			rise_q   <= rise_n;
			fall_q   <= fall_n;
			chan_q   <= chan_n;
			run_q    <= run_n;
			armed_q  <= armed_n;
			levels_q <= levels_n;
		end
	end

	// Delay table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				delay_q[i] <= DEFAULT_DELAY;
			end
		end else if (load_wr) begin
			delay_q[s1_index_s1[IDX_W-1:0]] <= s1_delay_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_levels_q <= levels_n;
			rsp_chan_q   <= chan_n;
			rsp_run_q    <= run_n;
			rsp_fired_q  <= fired_n;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.channel_levels = rsp_levels_q;
	assign rsp.channel_index  = rsp_chan_q;
	assign rsp.running        = rsp_run_q;
	assign rsp.fired          = rsp_fired_q;

	// Checks
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		chan_q < LAST_CHAN)
		else $error("scheduled channel out of range");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> tick_q == '0)
		else $error("tick counter not cleared while stopped");

	a_fired_level: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_fired_q |-> rsp_run_q && rsp_levels_q[rsp_chan_q[ENTRY_W-1:0]])
		else $error("fired result without running channel high");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(s1_opcode_s1))
		else $error("stalled command lost");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("advanced item produced no result");

endmodule

/* bench/spft_firing_checker.sv */
// Predictor and result checker for the sequenced pulse firing timer.
module spft_firing_checker
	import spft_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [DELAY_W-1:0] cfg_wr_data,
	spft_cmd_if                cmd,
	spft_rsp_if                rsp,
	output int                 mismatches,
	output int                 outstanding,
	output int                 rises_seen,
	output int                 sequences_done,
	output int                 results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// One status word as the block reports it after each command
	typedef struct packed {
		logic [LEVELS_W-1:0] levels;
		logic [CHAN_W-1:0]   chan;
		logic                run;
		logic                fired;
	} status_t;

	// Predicted timer state
	logic [TIME_W-1:0]   tick_count;
	logic [TIME_W-1:0]   rise_at;
	logic [TIME_W-1:0]   fall_at;
	logic [CHAN_W-1:0]   chan_now;
	logic                seq_running;
	logic                armed;
	logic [LEVELS_W-1:0] level_mask;
	logic [DELAY_W-1:0]  delay_tab [SPFT_CHANNELS];
	logic [DELAY_W-1:0]  pulse_len;

	// Expected status words, oldest first
	status_t expected_status_q [$];

	function automatic logic [LEVELS_W-1:0] chan_mask(input logic [CHAN_W-1:0] ch);
		return LEVELS_W'(1) << ch[ENTRY_W-1:0];
	endfunction

	function automatic void schedule_next_rise();
		rise_at = tick_count + TIME_W'(delay_tab[chan_now[ENTRY_W-1:0]]);
	endfunction

	// Back to channel zero with the counter cleared; levels stay put
	function automatic void restart_sequence();
		seq_running = 1'b0;
		tick_count  = '0;
		chan_now    = '0;
		fall_at     = '0;
		schedule_next_rise();
	endfunction

	function automatic void load_power_on_state();
		for (int ch = 0; ch < SPFT_CHANNELS; ch++)
			delay_tab[ch] = DEFAULT_DELAY;
		pulse_len  = DEFAULT_PULSE;
		level_mask = '0;
		armed      = 1'b1;
		restart_sequence();
	endfunction

	// Advance the predicted timer by one command and return the status it yields
	function automatic status_t apply_command(input logic [OPCODE_W-1:0] op,
			input logic [ENTRY_W-1:0] idx, input logic [DELAY_W-1:0] dly);
		status_t st;
		logic    rose;
		rose = 1'b0;
		case (op)
			OP_TICK: begin
				if (seq_running) begin
					tick_count = tick_count + TIME_W'(1);
					// rise compare has priority over the fall compare
					if (tick_count == rise_at) begin
						fall_at    = rise_at + TIME_W'(pulse_len);
						level_mask = level_mask | chan_mask(chan_now);
						rose       = 1'b1;
						rises_seen++;
					end else if (tick_count == fall_at) begin
						level_mask = level_mask & ~chan_mask(chan_now);
						chan_now   = chan_now + CHAN_W'(1);
						if (chan_now < CHAN_W'(SPFT_CHANNELS)) begin
							schedule_next_rise();
						end else begin
							// last channel done: stop, armed stays clear
							restart_sequence();
							sequences_done++;
						end
					end
				end
			end
			OP_PRESS: begin
				if (armed) begin
					armed       = 1'b0;
					seq_running = 1'b1;
				end else begin
					armed = 1'b1;
					restart_sequence();
				end
			end
			OP_LOAD: begin
				// a rise already scheduled is not recomputed
				if (32'(idx) < SPFT_CHANNELS)
					delay_tab[idx] = dly;
			end
			default: ;
		endcase
		st.levels = level_mask;
		st.chan   = chan_now;
		st.run    = seq_running;
		st.fired  = rose;
		return st;
	endfunction

	function automatic void flag_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			if (mismatches < 10)
				$display("[%0t] %s mismatch: expected %h, got %h", $realtime, field, want, got);
			mismatches++;
		end
	endfunction

	// Compare one result transfer against the oldest expectation
	function automatic void check_status();
		status_t want;
		if (expected_status_q.size() == 0) begin
			if (mismatches < 10)
				$display("[%0t] result transfer with no command outstanding", $realtime);
			mismatches++;
		end else begin
			want = expected_status_q.pop_front();
			flag_field("channel_levels", want.levels, rsp.channel_levels);
			flag_field("channel_index", 32'(want.chan), 32'(rsp.channel_index));
			flag_field("running", 32'(want.run), 32'(rsp.running));
			flag_field("fired", 32'(want.fired), 32'(rsp.fired));
			results_checked++;
		end
	endfunction

	// Watch config writes and both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_power_on_state();
			expected_status_q.delete();
			outstanding     <= 0;
			mismatches      = 0;
			rises_seen      = 0;
			sequences_done  = 0;
			results_checked = 0;
		end else begin
			if (cfg_wr_en)
				pulse_len = cfg_wr_data;
			if (rsp.valid && rsp.ready)
				check_status();
			if (cmd.valid && cmd.ready)
				expected_status_q.push_back(apply_command(cmd.opcode, cmd.entry_index,
					cmd.entry_delay));
			outstanding <= expected_status_q.size();
		end
	end

endmodule

/* bench/tb_sequenced_pulse_firing_timer_top.sv */
// Top of the pulse firing timer bench: clock, reset, command stimulus and verdict.
module tb_sequenced_pulse_firing_timer_top;
	import spft_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Opcode the block must treat as a no-op
	localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

	localparam int PHASES    = 6;
	localparam int LONG_HOLD = 400;

	// Pulse lengths per phase and the number of commands each one gets
	localparam int unsigned PULSE_PLAN [PHASES] = '{1, 2, 65535, 0, 3, 1};
	localparam int          BUDGET_PLAN [PHASES] = '{240, 240, 100, 100, 240, 240};

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [DELAY_W-1:0] cfg_wr_data;
	logic               last_running = 1'b0;

	int burst_left;
	int items_sent;
	int fail_count;
	int pending;
	int rises;
	int sequences;
	int checked;

	spft_cmd_if cmd_ch ();
	spft_rsp_if rsp_ch ();

	sequenced_pulse_firing_timer_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd_ch),
		.rsp         (rsp_ch)
	);

	spft_firing_checker firing_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.cmd             (cmd_ch),
		.rsp             (rsp_ch),
		.mismatches      (fail_count),
		.outstanding     (pending),
		.rises_seen      (rises),
		.sequences_done  (sequences),
		.results_checked (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a handshake never completes
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// Track whether the sequencer reported itself running in the last result
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready)
			last_running <= rsp_ch.running;
	end

	// Result side: random stall windows plus a periodic long hold-off
	initial begin
		int cyc;
		int stall_pct;
		rsp_ch.ready <= 1'b0;
		cyc       = 0;
		stall_pct = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 2500 == 1500) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				cyc += LONG_HOLD;
			end
			if (cyc % 64 == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 60;
					default: stall_pct = 85;
				endcase
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// One command transfer, with bursts and random gaps on the valid line
	task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [ENTRY_W-1:0] idx,
			input logic [DELAY_W-1:0] dly);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.opcode      <= op;
		cmd_ch.entry_index <= idx;
		cmd_ch.entry_delay <= dly;
		do @(posedge clk); while (!cmd_ch.ready);
		burst_left--;
		items_sent++;
	endtask

	task automatic wait_all_results();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Pulse length change only with nothing in flight
	task automatic write_pulse(input logic [DELAY_W-1:0] value);
		wait_all_results();
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Mostly short delays; rough picks also give zero, medium and full-range values
	function automatic logic [DELAY_W-1:0] pick_delay(input bit rough);
		int r;
		r = $urandom_range(0, 99);
		if (!rough)
			return (r < 98) ? DELAY_W'($urandom_range(1, 3)) : DELAY_W'($urandom_range(0, 12));
		if (r < 84)
			return DELAY_W'($urandom_range(1, 3));
		if (r < 88)
			return '0;
		if (r < 94)
			return DELAY_W'($urandom_range(4, 30));
		return DELAY_W'($urandom_range(0, 65535));
	endfunction

	task automatic send_junk(input logic [OPCODE_W-1:0] op);
		send_cmd(op, ENTRY_W'($urandom_range(0, 31)), DELAY_W'($urandom_range(0, 65535)));
	endtask

	// Load delays, get the sequencer running, then mostly ticks up to the phase budget
	task automatic run_session(input bit full_reload, input int stop_at);
		int len;
		int r;
		if (full_reload) begin
			for (int ch = 0; ch < SPFT_CHANNELS; ch++)
				send_cmd(OP_LOAD, ENTRY_W'(ch), pick_delay(1'b0));
		end else begin
			repeat (6) send_cmd(OP_LOAD, ENTRY_W'($urandom_range(0, 31)), pick_delay(1'b0));
		end
		// after an ended sequence the first press only resets, the second starts
		wait_all_results();
		repeat (2) begin
			if (!last_running) begin
				send_junk(OP_PRESS);
				wait_all_results();
			end
		end
		len = $urandom_range(60, 220);
		repeat (len) begin
			if (items_sent >= stop_at)
				break;
			r = $urandom_range(0, 99);
			if (r < 94)
				send_junk(OP_TICK);
			else if (r < 95)
				send_junk(OP_PRESS);
			else if (r < 99)
				send_cmd(OP_LOAD, ENTRY_W'($urandom_range(0, 31)), pick_delay(1'b1));
			else
				send_junk(OP_SPARE);
		end
	endtask

	// Main stimulus and verdict
	initial begin
		int first_item;
		int waited;
		bit full;
		arst_n             <= 1'b0;
		cfg_wr_en          <= 1'b0;
		cfg_wr_data        <= '0;
		cmd_ch.valid       <= 1'b0;
		cmd_ch.opcode      <= OP_TICK;
		cmd_ch.entry_index <= '0;
		cmd_ch.entry_delay <= '0;
		burst_left = 0;
		items_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: shortest pulse, both field extremes, every opcode
		write_pulse(16'd1);
		send_cmd(OP_SPARE, 5'd31, 16'hFFFF);
		send_cmd(OP_TICK, 5'd0, 16'd0);           // tick while stopped
		send_cmd(OP_LOAD, 5'd31, 16'hFFFF);
		send_cmd(OP_LOAD, 5'd30, 16'd0);
		send_cmd(OP_LOAD, 5'd0, 16'd1);
		send_cmd(OP_LOAD, 5'd1, 16'd2);
		send_cmd(OP_PRESS, 5'd0, 16'd0);          // start with the reset rise time
		send_cmd(OP_PRESS, 5'd0, 16'd0);          // stop-and-reset picks up new delay
		send_cmd(OP_PRESS, 5'd0, 16'd0);
		repeat (5) send_cmd(OP_TICK, 5'd0, 16'd0); // channel 0 and 1 rise and fall
		send_cmd(OP_PRESS, 5'd0, 16'd0);
		send_cmd(OP_TICK, 5'd0, 16'd0);
		send_cmd(OP_LOAD, 5'd0, 16'd0);           // zero delay, not yet scheduled
		send_cmd(OP_PRESS, 5'd0, 16'd0);
		send_cmd(OP_TICK, 5'd0, 16'd0);           // old rise time still fires
		send_cmd(OP_PRESS, 5'd0, 16'd0);          // stop keeps the level high
		send_cmd(OP_PRESS, 5'd0, 16'd0);
		repeat (2) send_cmd(OP_TICK, 5'd0, 16'd0); // zero delay never fires
		send_cmd(OP_PRESS, 5'd0, 16'd0);

		// Random phases over several pulse lengths
		for (int p = 0; p < PHASES; p++) begin
			write_pulse(DELAY_W'(PULSE_PLAN[p]));
			first_item = items_sent;
			full       = 1'b1;
			while (items_sent - first_item < BUDGET_PLAN[p]) begin
				run_session(full, first_item + BUDGET_PLAN[p]);
				full = 1'b0;
			end
		end

		// Drain with a bound, then let the pipeline settle
		cmd_ch.valid <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending != 0 && waited < 3000);
		repeat (8) @(posedge clk);

		$display("Drove %0d commands over %0d pulse length settings: %0d channel rises, %0d full sequences.",
			items_sent, PHASES + 1, rises, sequences);
		$display("%0d results compared, %0d mismatches, %0d left outstanding.",
			checked, fail_count, pending);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
hdl/spft_pkg.sv
hdl/spft_cmd_if.sv
hdl/spft_rsp_if.sv
hdl/sequenced_pulse_firing_timer_top.sv
bench/spft_firing_checker.sv
bench/tb_sequenced_pulse_firing_timer_top.sv
